// File: hw/rtl/grad_based_heading_angle_macros.svh
// Assertion macros shared by the heading angle RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef GRAD_BASED_HEADING_ANGLE_MACROS_SVH
`define GRAD_BASED_HEADING_ANGLE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GHD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Implication after a fixed number of cycles, disabled during reset.
`define GHD_ASSERT_AFTER(lbl, clk, rst_n, ante, dly, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/ghd_pkg.sv
// Shared widths, constants and types for the heading angle pipeline.
// Depends on nothing.
package ghd_pkg;

    localparam int DIST_W   = 16;              // |dx|, |dy|
    localparam int SUM_W    = DIST_W + 1;      // |dx| + |dy|
    localparam int Q_W      = 7;               // grad angle 0..100
    localparam int REM_W    = SUM_W + Q_W - 1; // 100*|dx| < 2^23
    localparam int ANG_W    = 9;               // 0..400
    localparam int MUL_W    = 17;              // (ang+9)*205

    localparam int GRAD_QUARTER = 100;
    localparam int GRAD_HALF    = 200;
    localparam int GRAD_FULL    = 400;
    localparam int MERGE_BIAS   = 9;
    // floor(x/10) == (x*205) >> 11 for x below 1029
    localparam int MERGE_RECIP  = 205;
    localparam int MERGE_SHIFT  = 11;

    // pipeline depth: 2 prep + 7 divide + 2 post stages
    localparam int PIPE_LAT = 2 + Q_W + 2;

    typedef struct packed {
        logic below;     // start_y < target_y
        logic west;      // target_x < start_x
        logic zero;      // points coincide
    } t_flags;

endpackage

// File: hw/rtl/ghd_prep.sv
// Front end: absolute offsets, quadrant flags, scaled numerator and sum.
// Depends on ghd_pkg.
module ghd_prep (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_vld,
    input  logic signed [ghd_pkg::DIST_W-1:0]   i_start_x,
    input  logic signed [ghd_pkg::DIST_W-1:0]   i_start_y,
    input  logic signed [ghd_pkg::DIST_W-1:0]   i_target_x,
    input  logic signed [ghd_pkg::DIST_W-1:0]   i_target_y,
    output logic                                o_vld,
    output logic        [ghd_pkg::REM_W-1:0]    o_num,
    output logic        [ghd_pkg::SUM_W-1:0]    o_den,
    output ghd_pkg::t_flags                     o_flags
);

    logic signed [ghd_pkg::SUM_W-1:0] dif_x;
    logic signed [ghd_pkg::SUM_W-1:0] dif_y;
    logic        [ghd_pkg::DIST_W-1:0] n_dx;
    logic        [ghd_pkg::DIST_W-1:0] n_dy;
    logic        [ghd_pkg::SUM_W-1:0]  n_sum;

    logic                        r_vld1;
    logic [ghd_pkg::DIST_W-1:0]  r_dx;
    logic [ghd_pkg::DIST_W-1:0]  r_dy;
    logic                        r_below1;
    logic                        r_west1;

    logic                        r_vld2;
    logic [ghd_pkg::REM_W-1:0]   r_num;
    logic [ghd_pkg::SUM_W-1:0]   r_den;
    ghd_pkg::t_flags             r_flags;

    always_comb begin
        dif_x = ghd_pkg::SUM_W'(i_target_x) - ghd_pkg::SUM_W'(i_start_x);
        dif_y = ghd_pkg::SUM_W'(i_start_y) - ghd_pkg::SUM_W'(i_target_y);
        n_dx  = dif_x[ghd_pkg::SUM_W-1] ? ghd_pkg::DIST_W'(-dif_x)
                                        : dif_x[ghd_pkg::DIST_W-1:0];
        n_dy  = dif_y[ghd_pkg::SUM_W-1] ? ghd_pkg::DIST_W'(-dif_y)
                                        : dif_y[ghd_pkg::DIST_W-1:0];
        n_sum = ghd_pkg::SUM_W'(r_dx) + ghd_pkg::SUM_W'(r_dy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
        r_dx          <= n_dx;
        r_dy          <= n_dy;
        r_below1      <= i_start_y < i_target_y;
        r_west1       <= i_target_x < i_start_x;
        r_num         <= ghd_pkg::REM_W'(r_dx) * ghd_pkg::REM_W'(ghd_pkg::GRAD_QUARTER);
        r_den         <= n_sum;
        r_flags.below <= r_below1;
        r_flags.west  <= r_west1;
        r_flags.zero  <= n_sum == '0;
    end

    assign o_vld   = r_vld2;
    assign o_num   = r_num;
    assign o_den   = r_den;
    assign o_flags = r_flags;

endmodule

// File: hw/rtl/ghd_div.sv
// Restoring divider, one quotient bit per pipeline stage, MSB first.
// Depends on ghd_pkg.
module ghd_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_vld,
    input  logic [ghd_pkg::REM_W-1:0]         i_num,
    input  logic [ghd_pkg::SUM_W-1:0]         i_den,
    input  ghd_pkg::t_flags                   i_flags,
    output logic                              o_vld,
    output logic [ghd_pkg::Q_W-1:0]           o_quo,
    output ghd_pkg::t_flags                   o_flags
);

    localparam int NS = ghd_pkg::Q_W;

    logic                        r_vld   [NS];
    logic [ghd_pkg::REM_W-1:0]   r_rem   [NS];
    logic [ghd_pkg::SUM_W-1:0]   r_den   [NS];
    logic [ghd_pkg::Q_W-1:0]     r_quo   [NS];
    ghd_pkg::t_flags             r_flags [NS];

    logic [ghd_pkg::REM_W-1:0]   src_rem [NS];
    logic [ghd_pkg::SUM_W-1:0]   src_den [NS];
    logic [ghd_pkg::Q_W-1:0]     src_quo [NS];
    logic [ghd_pkg::REM_W-1:0]   trial   [NS];
    logic                        take    [NS];
    logic [ghd_pkg::REM_W-1:0]   n_rem   [NS];
    logic [ghd_pkg::Q_W-1:0]     n_quo   [NS];

    always_comb begin
        src_rem[0] = i_num;
        src_den[0] = i_den;
        src_quo[0] = '0;
        for (int s = 1; s < NS; s++) begin
            src_rem[s] = r_rem[s-1];
            src_den[s] = r_den[s-1];
            src_quo[s] = r_quo[s-1];
        end
        for (int s = 0; s < NS; s++) begin
            // stage s decides quotient bit NS-1-s
            trial[s] = ghd_pkg::REM_W'(src_den[s]) << (NS - 1 - s);
            take[s]  = src_rem[s] >= trial[s];
            n_rem[s] = take[s] ? src_rem[s] - trial[s] : src_rem[s];
            n_quo[s] = {src_quo[s][ghd_pkg::Q_W-2:0], take[s]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NS; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_vld;
            for (int s = 1; s < NS; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
        r_flags[0] <= i_flags;
        for (int s = 1; s < NS; s++) begin
            r_flags[s] <= r_flags[s-1];
        end
        for (int s = 0; s < NS; s++) begin
            r_rem[s] <= n_rem[s];
            r_den[s] <= src_den[s];
            r_quo[s] <= n_quo[s];
        end
    end

    assign o_vld   = r_vld[NS-1];
    assign o_quo   = r_quo[NS-1];
    assign o_flags = r_flags[NS-1];

endmodule

// File: hw/rtl/ghd_post.sv
// Back end: quadrant fix-ups in grads, then merge of grads into degrees.
// Depends on ghd_pkg.
module ghd_post (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_vld,
    input  logic [ghd_pkg::Q_W-1:0]           i_quo,
    input  ghd_pkg::t_flags                   i_flags,
    output logic                              o_vld,
    output logic [ghd_pkg::ANG_W-1:0]         o_deg
);

    logic [ghd_pkg::ANG_W-1:0] ang_q;
    logic [ghd_pkg::ANG_W-1:0] ang_h;
    logic [ghd_pkg::ANG_W-1:0] n_ang;
    logic [ghd_pkg::ANG_W-1:0] biased;
    logic [ghd_pkg::MUL_W-1:0] prod;
    logic [ghd_pkg::ANG_W-1:0] n_deg;

    logic                      r_vld1;
    logic [ghd_pkg::ANG_W-1:0] r_ang;
    logic                      r_vld2;
    logic [ghd_pkg::ANG_W-1:0] r_deg;

    always_comb begin
        // the divider runs away on a zero sum: force the angle to 0
        ang_q  = i_flags.zero ? '0 : ghd_pkg::ANG_W'(i_quo);
        ang_h  = i_flags.below ? ghd_pkg::ANG_W'(ghd_pkg::GRAD_HALF) - ang_q : ang_q;
        n_ang  = i_flags.west ? ghd_pkg::ANG_W'(ghd_pkg::GRAD_FULL) - ang_h : ang_h;
        biased = r_ang + ghd_pkg::ANG_W'(ghd_pkg::MERGE_BIAS);
        prod   = ghd_pkg::MUL_W'(biased) * ghd_pkg::MUL_W'(ghd_pkg::MERGE_RECIP);
        n_deg  = r_ang - ghd_pkg::ANG_W'(prod >> ghd_pkg::MERGE_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
        r_ang <= n_ang;
        r_deg <= n_deg;
    end

    assign o_vld = r_vld2;
    assign o_deg = r_deg;

endmodule

// File: hw/rtl/grad_based_heading_angle.sv
// Heading angle top level: prep (2 stages), divider (7 stages), post (2 stages).
// Each accepted item yields one o_valid strobe after passing the prep, divider and post registers.
// Throughput: one item per cycle; busy stays low, the pipeline never stalls.
// The depth is set by the 7-bit quotient, one divider stage per bit.
// Reset is synchronous, active low, and clears only the stage valid bits.
// Depends on ghd_pkg, ghd_prep, ghd_div, ghd_post and the macros header.
`include "grad_based_heading_angle_macros.svh"

module grad_based_heading_angle (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [ghd_pkg::DIST_W-1:0] i_start_x,
    input  logic signed [ghd_pkg::DIST_W-1:0] i_start_y,
    input  logic signed [ghd_pkg::DIST_W-1:0] i_target_x,
    input  logic signed [ghd_pkg::DIST_W-1:0] i_target_y,
    output logic                              o_valid,
    output logic [ghd_pkg::ANG_W-1:0]         o_heading_degrees
);

    localparam int LAT = ghd_pkg::PIPE_LAT;

    logic                        acc;
    logic                        prep_vld;
    logic [ghd_pkg::REM_W-1:0]   prep_num;
    logic [ghd_pkg::SUM_W-1:0]   prep_den;
    ghd_pkg::t_flags             prep_flags;
    logic                        div_vld;
    logic [ghd_pkg::Q_W-1:0]     div_quo;
    ghd_pkg::t_flags             div_flags;

    assign busy = 1'b0;
    assign acc  = start && !busy;

    ghd_prep u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (acc),
        .i_start_x  (i_start_x),
        .i_start_y  (i_start_y),
        .i_target_x (i_target_x),
        .i_target_y (i_target_y),
        .o_vld      (prep_vld),
        .o_num      (prep_num),
        .o_den      (prep_den),
        .o_flags    (prep_flags)
    );

    ghd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (prep_vld),
        .i_num   (prep_num),
        .i_den   (prep_den),
        .i_flags (prep_flags),
        .o_vld   (div_vld),
        .o_quo   (div_quo),
        .o_flags (div_flags)
    );

    ghd_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (div_vld),
        .i_quo   (div_quo),
        .i_flags (div_flags),
        .o_vld   (o_valid),
        .o_deg   (o_heading_degrees)
    );

    `GHD_ASSERT_AFTER(a_item_returns, i_clk, i_rst_n, acc, LAT, o_valid, "accepted item lost")
    `GHD_ASSERT_NOW(a_no_stray_result, i_clk, i_rst_n, o_valid, $past(acc, LAT), "result without item")
    `GHD_ASSERT_NOW(a_heading_range, i_clk, i_rst_n, o_valid, o_heading_degrees <= 9'd360, "heading above 360")
    `GHD_ASSERT_NOW(a_zero_vector, i_clk, i_rst_n, div_vld && div_flags.zero, div_flags == '0 || (!div_flags.below && !div_flags.west), "coincident points flagged off quadrant")

endmodule

// File: tb/sv/grad_based_heading_angle_tb.sv
// Self-checking bench for grad_based_heading_angle: queued point pairs, a scoreboard of headings.
// Each accepted item's heading is predicted in-bench and compared when o_valid strobes.
// Depends on ghd_pkg and the grad_based_heading_angle RTL.
module grad_based_heading_angle_tb;

    localparam int N_RANDOM    = 1250;
    localparam int IDLE_PCT    = 32;
    localparam int QUIET_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic signed [ghd_pkg::DIST_W-1:0] sx;
        logic signed [ghd_pkg::DIST_W-1:0] sy;
        logic signed [ghd_pkg::DIST_W-1:0] tx;
        logic signed [ghd_pkg::DIST_W-1:0] ty;
        bit                                drain_first; // hold until all headings are back
        bit                                steady;      // never idle before this item
    } t_heading_req;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              start = 1'b0;
    logic                              busy;
    logic signed [ghd_pkg::DIST_W-1:0] i_start_x = '0;
    logic signed [ghd_pkg::DIST_W-1:0] i_start_y = '0;
    logic signed [ghd_pkg::DIST_W-1:0] i_target_x = '0;
    logic signed [ghd_pkg::DIST_W-1:0] i_target_y = '0;
    logic                              o_valid;
    logic [ghd_pkg::ANG_W-1:0]         o_heading_degrees;

    t_heading_req              pending_reqs[$];
    logic [ghd_pkg::ANG_W-1:0] expected_headings[$];
    bit                        took_item = 1'b0;
    int                        quiet_cycles = 0;
    int                        mismatches = 0;
    int                        results_seen = 0;

    grad_based_heading_angle dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_start_x         (i_start_x),
        .i_start_y         (i_start_y),
        .i_target_x        (i_target_x),
        .i_target_y        (i_target_y),
        .o_valid           (o_valid),
        .o_heading_degrees (o_heading_degrees)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Fold the offset into the first quadrant, fix up the quadrant, merge grads to degrees.
    function automatic logic [ghd_pkg::ANG_W-1:0] heading_of(
        input logic signed [ghd_pkg::DIST_W-1:0] sx,
        input logic signed [ghd_pkg::DIST_W-1:0] sy,
        input logic signed [ghd_pkg::DIST_W-1:0] tx,
        input logic signed [ghd_pkg::DIST_W-1:0] ty
    );
        int dx;
        int dy;
        int ang;
        dx = int'(tx) - int'(sx);
        dy = int'(sy) - int'(ty);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        ang = 0;
        if (dx + dy != 0) ang = (ghd_pkg::GRAD_QUARTER * dx) / (dx + dy);
        if (sy < ty) ang = ghd_pkg::GRAD_HALF - ang;
        if (tx < sx) ang = ghd_pkg::GRAD_FULL - ang;
        ang = ang - (ang + ghd_pkg::MERGE_BIAS) / 10;
        return ang[ghd_pkg::ANG_W-1:0];
    endfunction

    function automatic logic signed [ghd_pkg::DIST_W-1:0] clamp_coord(input int v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[ghd_pkg::DIST_W-1:0];
    endfunction

    function automatic logic signed [ghd_pkg::DIST_W-1:0] corner_coord();
        case ($urandom_range(4))
            0: return 16'sh8000;
            1: return 16'shffff;
            2: return 16'sh0000;
            3: return 16'sh0001;
            default: return 16'sh7fff;
        endcase
    endfunction

    task automatic add_req(input int sx, input int sy, input int tx, input int ty,
                           input bit drain_first, input bit steady);
        t_heading_req r;
        r.sx = clamp_coord(sx);
        r.sy = clamp_coord(sy);
        r.tx = clamp_coord(tx);
        r.ty = clamp_coord(ty);
        r.drain_first = drain_first;
        r.steady = steady;
        pending_reqs.push_back(r);
    endtask

    // Driver: present the oldest pending item at the falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !took_item) begin
            // hold the offered item until it is taken
        end else if (pending_reqs.size() == 0) begin
            start <= 1'b0;
        end else if (pending_reqs[0].drain_first && expected_headings.size() != 0) begin
            start <= 1'b0;
        end else if (!pending_reqs[0].steady && $urandom_range(99) < IDLE_PCT) begin
            start <= 1'b0;
        end else begin
            start      <= 1'b1;
            i_start_x  <= pending_reqs[0].sx;
            i_start_y  <= pending_reqs[0].sy;
            i_target_x <= pending_reqs[0].tx;
            i_target_y <= pending_reqs[0].ty;
        end
    end

    // Monitor: take items and results at the rising edge.
    always @(posedge i_clk) begin
        logic [ghd_pkg::ANG_W-1:0] want;
        took_item = i_rst_n && start && !busy;
        if (took_item) begin
            expected_headings.push_back(heading_of(i_start_x, i_start_y,
                                                   i_target_x, i_target_y));
            void'(pending_reqs.pop_front());
        end
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (expected_headings.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result %0d: heading %0d with no item outstanding",
                             results_seen, o_heading_degrees);
            end else begin
                want = expected_headings.pop_front();
                if (o_heading_degrees !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("result %0d: heading expected %0d, got %0d",
                                 results_seen, want, o_heading_degrees);
                end
            end
        end
        if (took_item || (i_rst_n && o_valid)) quiet_cycles = 0;
        else quiet_cycles++;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int sx;
        int sy;
        int tx;
        int ty;
        int kind;

        // Directed: equal points, axes, diagonals, full-range offsets.
        add_req(0, 0, 0, 0, 0, 0);
        add_req(32767, 32767, 32767, 32767, 0, 0);
        add_req(-32768, -32768, -32768, -32768, 0, 0);
        add_req(0, 0, 0, -5, 0, 0);
        add_req(0, 0, 5, 0, 0, 0);
        add_req(0, 0, 0, 5, 0, 0);
        add_req(0, 0, -5, 0, 0, 0);
        add_req(0, 0, 7, -7, 0, 0);
        add_req(0, 0, 7, 7, 0, 0);
        add_req(0, 0, -7, 7, 0, 0);
        add_req(0, 0, -7, -7, 0, 0);
        add_req(-32768, 32767, 32767, -32768, 0, 0);
        add_req(-32768, -32768, 32767, 32767, 0, 0);
        add_req(32767, -32768, -32768, 32767, 0, 0);
        add_req(32767, 32767, -32768, -32768, 0, 0);
        add_req(-32768, 0, 32767, 0, 0, 0);
        add_req(32767, 0, -32768, 0, 0, 0);
        add_req(0, 32767, 0, -32768, 0, 0);
        add_req(0, -32768, 0, 32767, 0, 0);
        add_req(0, 0, 1, -32768, 0, 0);
        add_req(0, 0, 32767, -1, 0, 0);
        add_req(-1, -1, 0, 0, 0, 0);
        add_req(100, 100, 101, 97, 0, 0);

        // Random: full range, near pairs, corner values, one axis shared.
        for (int n = 0; n < N_RANDOM; n++) begin
            kind = $urandom_range(99);
            sx = $signed(16'($urandom));
            sy = $signed(16'($urandom));
            tx = $signed(16'($urandom));
            ty = $signed(16'($urandom));
            if (kind < 30) begin
                tx = sx + $urandom_range(16) - 8;
                ty = sy + $urandom_range(16) - 8;
            end else if (kind < 45) begin
                sx = corner_coord();
                sy = corner_coord();
                tx = corner_coord();
                ty = corner_coord();
            end else if (kind < 52) begin
                tx = sx;
            end else if (kind < 60) begin
                ty = sy;
            end
            add_req(sx, sy, tx, ty, n == 0 || n == 700, n >= 400 && n < 600);
        end

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        while (pending_reqs.size() != 0 || expected_headings.size() != 0)
            @(posedge i_clk);
        repeat (ghd_pkg::PIPE_LAT + 4) @(posedge i_clk);

        if (mismatches == 0 && expected_headings.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
